/* rtl/nfs_op_per_client_counter_top_macros.svh */
// Assertion helpers shared by the counter table RTL.
`ifndef NFS_OP_PER_CLIENT_COUNTER_TOP_MACROS_SVH
`define NFS_OP_PER_CLIENT_COUNTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define NFSC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define NFSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/nfsc_pkg.sv */
package nfsc_pkg;

    localparam int CLIENT_SLOTS = 64;
    localparam int SLOT_W       = $clog2(CLIENT_SLOTS);
    localparam int NUM_OPS      = 24;
    localparam int OP_W         = 5;
    localparam int ADDR_W       = 32;
    localparam int V2_PROCS     = 18;
    localparam int V3_PROCS     = 22;
    localparam int OPC_DEPTH    = CLIENT_SLOTS * NUM_OPS;
    localparam int OPC_AW       = $clog2(OPC_DEPTH);

    localparam logic [7:0] NFS_V2 = 8'd2;
    localparam logic [7:0] NFS_V3 = 8'd3;

    // ST_FULL doubles as "lookup pending" for a record until a cell claims it,
    // ST_EMPTY likewise for a read request.
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_REPLY    = 3'd1,
        ST_BAD_VER  = 3'd2,
        ST_BAD_PROC = 3'd3,
        ST_FULL     = 3'd4,
        ST_EMPTY    = 3'd5
    } t_status;

    typedef enum logic {
        REQ_RECORD = 1'b0,
        REQ_READ   = 1'b1
    } t_req;

    typedef enum logic {
        TAIL_IDLE,
        TAIL_READ
    } t_tail_state;

    // v3 procedure to unified operation
    localparam logic [OP_W-1:0] V3_MAP [V3_PROCS] = '{
        5'd0,  5'd1,  5'd2,  5'd4,  5'd18, 5'd5,  5'd6,  5'd8,  5'd9,  5'd14, 5'd13,
        5'd19, 5'd10, 5'd15, 5'd11, 5'd12, 5'd16, 5'd20, 5'd17, 5'd21, 5'd22, 5'd23
    };

    // Request travelling down the cell row
    typedef struct packed {
        logic              vld;
        logic              rd;
        logic              live;
        logic              hit;
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] key;
        logic [OP_W-1:0]   op;
        logic              intr;
    } t_pkt;

    typedef struct packed {
        t_status         status;
        logic [OP_W-1:0] op;
    } t_map;

    function automatic t_map map_proc(input logic [7:0] ver, input logic [7:0] proc);
        t_map m;
        m.status = ST_FULL;
        m.op     = '0;
        if (ver == NFS_V2) begin
            if (proc < 8'(V2_PROCS)) begin
                m.op = proc[OP_W-1:0];
            end else begin
                m.status = ST_BAD_PROC;
            end
        end else if (ver == NFS_V3) begin
            if (proc < 8'(V3_PROCS)) begin
                m.op = V3_MAP[proc[OP_W-1:0]];
            end else begin
                m.status = ST_BAD_PROC;
            end
        end else begin
            m.status = ST_BAD_VER;
        end
        return m;
    endfunction

endpackage

/* rtl/nfs_op_per_client_counter_top.sv */
// Per-client NFS call counter table.
// Input channel: i_in_valid / o_in_stall with one request per accepted beat. A
// record request counts a valid NFS call against its client; a read request
// returns one slot's key and counters. Output channel: o_out_valid /
// i_out_stall, exactly one result per request, in request order.
// Configuration: i_cfg_valid / o_cfg_ready writes the interesting-operation
// mask; write it only while no request is in flight.
// Path from acceptance to o_out_valid: one entry stage, the client cells in
// order, then the per-operation count read-modify-write in the tail.
// The cell row advances only while the tail is idle, so a request is taken
// only once the tail has finished the read-modify-write of the per-operation
// count memory at the end of the cell row for the request ahead of it.
// Reset: all slots freed, mask cleared, then a clearing pass over all
// CLIENT_SLOTS * 24 = 1536 entries zeroes the per-operation counts; o_in_stall
// stays high until it finishes. Configuration writes are taken throughout.
// When the receiver stalls, the finished result holds in the output register,
// the next one waits in the tail and the cell row freezes, raising o_in_stall.
`include "nfs_op_per_client_counter_top_macros.svh"

module nfs_op_per_client_counter_top #(
    parameter int COUNTER_BITS = 48
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [nfsc_pkg::NUM_OPS-1:0]        i_cfg_interesting_mask,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_req_type,
    input  logic                                i_is_call,
    input  logic [7:0]                          i_nfs_version,
    input  logic [7:0]                          i_proc_number,
    input  logic [nfsc_pkg::ADDR_W-1:0]         i_client_addr,
    input  logic [nfsc_pkg::SLOT_W-1:0]         i_read_slot,
    input  logic [nfsc_pkg::OP_W-1:0]           i_read_op,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [2:0]                          o_status,
    output logic [nfsc_pkg::SLOT_W-1:0]         o_slot,
    output logic [nfsc_pkg::ADDR_W-1:0]         o_key_addr,
    output logic [nfsc_pkg::OP_W-1:0]           o_unified_op,
    output logic                                o_was_interesting,
    output logic [COUNTER_BITS-1:0]             o_total_count,
    output logic [COUNTER_BITS-1:0]             o_interesting_count,
    output logic [COUNTER_BITS-1:0]             o_op_count
);

    import nfsc_pkg::*;

    localparam int MASK_EXT_W = 1 << OP_W;

    logic [NUM_OPS-1:0]      r_mask;
    logic [MASK_EXT_W-1:0]   w_mask_ext;
    t_pkt                    r_pkt0, n_pkt0;
    t_map                    w_map;
    logic                    w_adv;
    logic                    w_accept;

    t_pkt                    w_pkt   [CLIENT_SLOTS+1];
    logic [COUNTER_BITS-1:0] w_total [CLIENT_SLOTS+1];
    logic [COUNTER_BITS-1:0] w_icnt  [CLIENT_SLOTS+1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_cfg_valid) begin
            r_mask <= i_cfg_interesting_mask;
        end
    end

    assign w_mask_ext = MASK_EXT_W'(r_mask);
    assign o_in_stall = !w_adv;
    assign w_accept   = i_in_valid && w_adv;
    assign w_map      = map_proc(i_nfs_version, i_proc_number);

    // classify the request; only lookups travel live through the cells
    always_comb begin
        n_pkt0     = '0;
        n_pkt0.vld = w_accept;
        if (i_req_type == REQ_READ) begin
            n_pkt0.rd     = 1'b1;
            n_pkt0.live   = 1'b1;
            n_pkt0.status = ST_EMPTY;
            n_pkt0.slot   = i_read_slot;
            n_pkt0.op     = i_read_op;
            n_pkt0.intr   = w_mask_ext[i_read_op];
        end else if (!i_is_call) begin
            n_pkt0.status = ST_REPLY;
        end else begin
            n_pkt0.status = w_map.status;
            if (w_map.status == ST_FULL) begin
                n_pkt0.live = 1'b1;
                n_pkt0.key  = i_client_addr;
                n_pkt0.op   = w_map.op;
                n_pkt0.intr = w_mask_ext[w_map.op];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt0.vld <= 1'b0;
        end else if (w_adv) begin
            r_pkt0 <= n_pkt0;
        end
    end

    assign w_pkt[0]   = r_pkt0;
    assign w_total[0] = '0;
    assign w_icnt[0]  = '0;

    for (genvar g = 0; g < CLIENT_SLOTS; g++) begin : g_cell
        nfsc_cell #(
            .COUNTER_BITS (COUNTER_BITS),
            .IDX          (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_pkt   (w_pkt[g]),
            .i_total (w_total[g]),
            .i_icnt  (w_icnt[g]),
            .o_pkt   (w_pkt[g+1]),
            .o_total (w_total[g+1]),
            .o_icnt  (w_icnt[g+1])
        );
    end

    nfsc_tail #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_tail (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_pkt               (w_pkt[CLIENT_SLOTS]),
        .i_total             (w_total[CLIENT_SLOTS]),
        .i_icnt              (w_icnt[CLIENT_SLOTS]),
        .o_ready             (w_adv),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_status            (o_status),
        .o_slot              (o_slot),
        .o_key_addr          (o_key_addr),
        .o_unified_op        (o_unified_op),
        .o_was_interesting   (o_was_interesting),
        .o_total_count       (o_total_count),
        .o_interesting_count (o_interesting_count),
        .o_op_count          (o_op_count)
    );

    `NFSC_ASSERT_NEXT(a_entry_loaded, i_clk, i_rst_n, w_accept, r_pkt0.vld, "accepted request not staged")

endmodule

/* rtl/nfsc_ram.sv */
module nfsc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1536,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/nfsc_cell.sv */
`include "nfs_op_per_client_counter_top_macros.svh"

module nfsc_cell #(
    parameter int COUNTER_BITS = 48,
    parameter int IDX          = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  nfsc_pkg::t_pkt          i_pkt,
    input  logic [COUNTER_BITS-1:0] i_total,
    input  logic [COUNTER_BITS-1:0] i_icnt,
    output nfsc_pkg::t_pkt          o_pkt,
    output logic [COUNTER_BITS-1:0] o_total,
    output logic [COUNTER_BITS-1:0] o_icnt
);

    import nfsc_pkg::*;

    localparam logic [COUNTER_BITS-1:0] CNT_ONE = COUNTER_BITS'(1);
    localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;
    localparam logic [SLOT_W-1:0]       MY_SLOT = SLOT_W'(IDX);

    logic                    r_valid,   n_valid;
    logic [ADDR_W-1:0]       r_key,     n_key;
    logic [COUNTER_BITS-1:0] r_total,   n_total;
    logic [COUNTER_BITS-1:0] r_icnt,    n_icnt;
    t_pkt                    r_pkt,     n_pkt;
    logic [COUNTER_BITS-1:0] r_out_tot, n_out_tot;
    logic [COUNTER_BITS-1:0] r_out_ic,  n_out_ic;
    logic [COUNTER_BITS-1:0] w_total_inc;
    logic [COUNTER_BITS-1:0] w_icnt_inc;
    logic                    w_take;

    assign w_total_inc = (r_total == CNT_MAX) ? r_total : r_total + CNT_ONE;
    assign w_icnt_inc  = (r_icnt  == CNT_MAX) ? r_icnt  : r_icnt  + CNT_ONE;
    assign w_take      = i_pkt.vld && i_pkt.live && !i_pkt.hit;

    always_comb begin
        n_valid   = r_valid;
        n_key     = r_key;
        n_total   = r_total;
        n_icnt    = r_icnt;
        n_pkt     = i_pkt;
        n_out_tot = i_total;
        n_out_ic  = i_icnt;
        if (w_take) begin
            if (i_pkt.rd) begin
                if (r_valid && i_pkt.slot == MY_SLOT) begin
                    n_pkt.hit    = 1'b1;
                    n_pkt.status = ST_OK;
                    n_pkt.key    = r_key;
                    n_out_tot    = r_total;
                    n_out_ic     = r_icnt;
                end
            end else if (r_valid && r_key == i_pkt.key) begin
                n_pkt.hit    = 1'b1;
                n_pkt.status = ST_OK;
                n_pkt.slot   = MY_SLOT;
                n_total      = w_total_inc;
                n_icnt       = i_pkt.intr ? w_icnt_inc : r_icnt;
                n_out_tot    = n_total;
                n_out_ic     = n_icnt;
            end else if (!r_valid) begin
                // first free slot: claim it, counters start fresh
                n_pkt.hit    = 1'b1;
                n_pkt.status = ST_OK;
                n_pkt.slot   = MY_SLOT;
                n_valid      = 1'b1;
                n_key        = i_pkt.key;
                n_total      = CNT_ONE;
                n_icnt       = i_pkt.intr ? CNT_ONE : '0;
                n_out_tot    = n_total;
                n_out_ic     = n_icnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_pkt.vld <= 1'b0;
        end else if (i_adv) begin
            r_valid   <= n_valid;
            r_key     <= n_key;
            r_total   <= n_total;
            r_icnt    <= n_icnt;
            r_pkt     <= n_pkt;
            r_out_tot <= n_out_tot;
            r_out_ic  <= n_out_ic;
        end
    end

    assign o_pkt   = r_pkt;
    assign o_total = r_out_tot;
    assign o_icnt  = r_out_ic;

    `NFSC_ASSERT_NEXT(a_slot_kept, i_clk, i_rst_n, r_valid, r_valid, "allocated slot released")
    `NFSC_ASSERT_IMPL(a_take_keeps_order, i_clk, i_rst_n, i_adv && w_take && !i_pkt.rd && !r_valid, n_pkt.slot == MY_SLOT, "free slot not claimed")

endmodule

/* rtl/nfsc_tail.sv */
`include "nfs_op_per_client_counter_top_macros.svh"

module nfsc_tail #(
    parameter int COUNTER_BITS = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nfsc_pkg::t_pkt                i_pkt,
    input  logic [COUNTER_BITS-1:0]       i_total,
    input  logic [COUNTER_BITS-1:0]       i_icnt,
    output logic                          o_ready,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [2:0]                    o_status,
    output logic [nfsc_pkg::SLOT_W-1:0]   o_slot,
    output logic [nfsc_pkg::ADDR_W-1:0]   o_key_addr,
    output logic [nfsc_pkg::OP_W-1:0]     o_unified_op,
    output logic                          o_was_interesting,
    output logic [COUNTER_BITS-1:0]       o_total_count,
    output logic [COUNTER_BITS-1:0]       o_interesting_count,
    output logic [COUNTER_BITS-1:0]       o_op_count
);

    import nfsc_pkg::*;

    localparam logic [COUNTER_BITS-1:0] CNT_ONE  = COUNTER_BITS'(1);
    localparam logic [COUNTER_BITS-1:0] CNT_MAX  = '1;
    localparam logic [OPC_AW-1:0]       OPC_LAST = OPC_AW'(OPC_DEPTH - 1);

    function automatic logic [OPC_AW-1:0] opc_addr(input logic [SLOT_W-1:0] slot,
                                                  input logic [OP_W-1:0] op);
        return OPC_AW'(slot) * OPC_AW'(NUM_OPS) + OPC_AW'(op);
    endfunction

    t_tail_state             r_state, n_state;
    t_pkt                    r_pkt;
    logic [COUNTER_BITS-1:0] r_total;
    logic [COUNTER_BITS-1:0] r_icnt;
    logic                    r_use_mem;
    logic                    r_clr_busy;
    logic [OPC_AW-1:0]       r_clr_addr;

    logic                    r_out_vld;
    t_status                 r_out_status;
    logic [SLOT_W-1:0]       r_out_slot;
    logic [ADDR_W-1:0]       r_out_key;
    logic [OP_W-1:0]         r_out_op;
    logic                    r_out_intr;
    logic [COUNTER_BITS-1:0] r_out_total;
    logic [COUNTER_BITS-1:0] r_out_icnt;
    logic [COUNTER_BITS-1:0] r_out_opcnt;

    logic                    w_out_free;
    logic                    w_take;
    logic                    w_load;
    logic                    w_rd_en;
    logic                    w_wr_bump;
    logic                    w_bump;
    logic [COUNTER_BITS-1:0] w_rd_data;
    logic [COUNTER_BITS-1:0] w_base;
    logic [COUNTER_BITS-1:0] w_opcnt;
    logic                    w_wr_en;
    logic [OPC_AW-1:0]       w_wr_addr;
    logic [COUNTER_BITS-1:0] w_wr_data;

    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_base     = r_use_mem ? w_rd_data : '0;
    assign w_bump     = !r_pkt.rd && r_pkt.hit && r_pkt.intr;
    assign w_opcnt    = (w_bump && w_base != CNT_MAX) ? w_base + CNT_ONE : w_base;

    always_comb begin
        n_state   = r_state;
        w_take    = 1'b0;
        w_load    = 1'b0;
        w_rd_en   = 1'b0;
        w_wr_bump = 1'b0;
        unique case (r_state)
            TAIL_IDLE: begin
                if (i_pkt.vld && !r_clr_busy) begin
                    w_take  = 1'b1;
                    w_rd_en = i_pkt.hit && (i_pkt.op < OP_W'(NUM_OPS));
                    n_state = TAIL_READ;
                end
            end
            TAIL_READ: begin
                // write back and hand over only once the output register is free
                if (w_out_free) begin
                    w_load    = 1'b1;
                    w_wr_bump = w_bump;
                    n_state   = TAIL_IDLE;
                end
            end
            default: n_state = TAIL_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TAIL_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_pkt     <= i_pkt;
            r_total   <= i_total;
            r_icnt    <= i_icnt;
            r_use_mem <= w_rd_en;
        end
    end

    // zero the per-operation counts once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == OPC_LAST) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + OPC_AW'(1);
            end
        end
    end

    assign w_wr_en   = r_clr_busy || w_wr_bump;
    assign w_wr_addr = r_clr_busy ? r_clr_addr : opc_addr(r_pkt.slot, r_pkt.op);
    assign w_wr_data = r_clr_busy ? '0 : w_opcnt;

    nfsc_ram #(
        .WIDTH (COUNTER_BITS),
        .DEPTH (OPC_DEPTH)
    ) u_opc_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (opc_addr(i_pkt.slot, i_pkt.op)),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_status <= r_pkt.status;
            r_out_slot   <= r_pkt.slot;
            r_out_key    <= r_pkt.key;
            r_out_op     <= r_pkt.op;
            r_out_intr   <= r_pkt.intr;
            r_out_total  <= r_total;
            r_out_icnt   <= r_icnt;
            r_out_opcnt  <= w_opcnt;
        end
    end

    assign o_ready             = (r_state == TAIL_IDLE) && !r_clr_busy;
    assign o_out_valid         = r_out_vld;
    assign o_status            = r_out_status;
    assign o_slot              = r_out_slot;
    assign o_key_addr          = r_out_key;
    assign o_unified_op        = r_out_op;
    assign o_was_interesting   = r_out_intr;
    assign o_total_count       = r_out_total;
    assign o_interesting_count = r_out_icnt;
    assign o_op_count          = r_out_opcnt;

    `NFSC_ASSERT_IMPL(a_quiet_in_clear, i_clk, i_rst_n, r_clr_busy, !r_out_vld && r_state == TAIL_IDLE, "activity during clearing pass")
    `NFSC_ASSERT_IMPL(a_hit_is_ok, i_clk, i_rst_n, (r_state == TAIL_READ) && r_pkt.hit, r_pkt.status == ST_OK, "matched request without ok status")

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import nfsc_pkg::*;

    localparam int CNT_W = 48;
    localparam logic [CNT_W-1:0] CNT_TOP = {CNT_W{1'b1}};
    localparam int POOL_SIZE = 128;
    localparam int DRAIN_CYCLES = CLIENT_SLOTS + 16;

    // v3 procedure number to unified operation
    localparam logic [OP_W-1:0] V3_TO_OP [V3_PROCS] = '{
        5'd0, 5'd1, 5'd2, 5'd4, 5'd18, 5'd5, 5'd6, 5'd8, 5'd9, 5'd14, 5'd13,
        5'd19, 5'd10, 5'd15, 5'd11, 5'd12, 5'd16, 5'd20, 5'd17, 5'd21, 5'd22, 5'd23
    };

    typedef struct packed {
        t_req              kind;
        logic              is_call;
        logic [7:0]        ver;
        logic [7:0]        proc;
        logic [ADDR_W-1:0] addr;
        logic [SLOT_W-1:0] rslot;
        logic [OP_W-1:0]   rop;
    } t_nfs_req;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] key;
        logic [OP_W-1:0]   op;
        logic              intr;
        logic [CNT_W-1:0]  total;
        logic [CNT_W-1:0]  icount;
        logic [CNT_W-1:0]  opcount;
    } t_call_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [NUM_OPS-1:0] i_cfg_interesting_mask = '0;
    logic i_in_valid = 1'b0;
    logic i_out_stall = 1'b0;
    t_nfs_req cur_req = '0;

    logic o_cfg_ready;
    logic o_in_stall;
    logic o_out_valid;
    logic [2:0] o_status;
    logic [SLOT_W-1:0] o_slot;
    logic [ADDR_W-1:0] o_key_addr;
    logic [OP_W-1:0] o_unified_op;
    logic o_was_interesting;
    logic [CNT_W-1:0] o_total_count;
    logic [CNT_W-1:0] o_interesting_count;
    logic [CNT_W-1:0] o_op_count;

    // predictor copy of the table
    logic [NUM_OPS-1:0] mask_model = '0;
    logic slot_used [CLIENT_SLOTS];
    logic [ADDR_W-1:0] slot_addr [CLIENT_SLOTS];
    logic [CNT_W-1:0] call_cnt [CLIENT_SLOTS];
    logic [CNT_W-1:0] intr_cnt [CLIENT_SLOTS];
    logic [CNT_W-1:0] op_cnt [CLIENT_SLOTS][NUM_OPS];

    t_nfs_req pending_reqs [$];
    t_call_result expected_results [$];
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

    int n_queued = 0;
    int n_accepted = 0;
    int n_errors = 0;
    logic in_fired = 1'b0;
    int in_gap = 0;
    int in_calm = 0;
    int stall_left = 0;
    int stall_calm = 0;

    nfs_op_per_client_counter_top #(
        .COUNTER_BITS(CNT_W)
    ) DUT (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_interesting_mask (i_cfg_interesting_mask),
        .i_in_valid             (i_in_valid),
        .o_in_stall             (o_in_stall),
        .i_req_type             (cur_req.kind),
        .i_is_call              (cur_req.is_call),
        .i_nfs_version          (cur_req.ver),
        .i_proc_number          (cur_req.proc),
        .i_client_addr          (cur_req.addr),
        .i_read_slot            (cur_req.rslot),
        .i_read_op              (cur_req.rop),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .o_status               (o_status),
        .o_slot                 (o_slot),
        .o_key_addr             (o_key_addr),
        .o_unified_op           (o_unified_op),
        .o_was_interesting      (o_was_interesting),
        .o_total_count          (o_total_count),
        .o_interesting_count    (o_interesting_count),
        .o_op_count             (o_op_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic op_is_counted(input logic [OP_W-1:0] op);
        if (op >= NUM_OPS) begin
            return 1'b0;
        end
        return mask_model[op];
    endfunction

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == CNT_TOP) ? v : v + 1'b1;
    endfunction

    // Apply one request to the table copy and return the result it should produce.
    function automatic t_call_result count_request(input t_nfs_req r);
        t_call_result res;
        logic [OP_W-1:0] op;
        int hit;
        int free_s;
        res = '0;
        if (r.kind == REQ_READ) begin
            res.slot = r.rslot;
            res.op   = r.rop;
            res.intr = op_is_counted(r.rop);
            if (!slot_used[r.rslot]) begin
                res.status = ST_EMPTY;
            end else begin
                res.status  = ST_OK;
                res.key     = slot_addr[r.rslot];
                res.total   = call_cnt[r.rslot];
                res.icount  = intr_cnt[r.rslot];
                res.opcount = (r.rop < NUM_OPS) ? op_cnt[r.rslot][r.rop] : '0;
            end
            return res;
        end
        if (!r.is_call) begin
            res.status = ST_REPLY;
            return res;
        end
        if (r.ver == NFS_V2 && r.proc < V2_PROCS) begin
            op = r.proc[OP_W-1:0];
        end else if (r.ver == NFS_V3 && r.proc < V3_PROCS) begin
            op = V3_TO_OP[r.proc[OP_W-1:0]];
        end else begin
            if (r.ver == NFS_V2 || r.ver == NFS_V3) begin
                res.status = ST_BAD_PROC;
            end else begin
                res.status = ST_BAD_VER;
            end
            return res;
        end
        res.op   = op;
        res.intr = op_is_counted(op);
        hit    = -1;
        free_s = -1;
        for (int s = 0; s < CLIENT_SLOTS; s++) begin
            if (slot_used[s]) begin
                if (slot_addr[s] == r.addr && hit < 0) begin
                    hit = s;
                end
            end else if (free_s < 0) begin
                free_s = s;
            end
        end
        if (hit < 0) begin
            if (free_s < 0) begin
                res.status = ST_FULL;
                res.key    = r.addr;
                return res;
            end
            hit = free_s;
            slot_used[hit] = 1'b1;
            slot_addr[hit] = r.addr;
            call_cnt[hit]  = '0;
            intr_cnt[hit]  = '0;
            for (int u = 0; u < NUM_OPS; u++) begin
                op_cnt[hit][u] = '0;
            end
        end
        call_cnt[hit] = bump(call_cnt[hit]);
        if (res.intr) begin
            intr_cnt[hit]    = bump(intr_cnt[hit]);
            op_cnt[hit][op]  = bump(op_cnt[hit][op]);
        end
        res.status  = ST_OK;
        res.slot    = hit[SLOT_W-1:0];
        res.key     = r.addr;
        res.total   = call_cnt[hit];
        res.icount  = intr_cnt[hit];
        res.opcount = op_cnt[hit][op];
        return res;
    endfunction

    task automatic check_result(input t_call_result e);
        if (o_status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, o_status);
            n_errors++;
        end
        if (o_slot !== e.slot) begin
            $error("slot: expected %0d, got %0d", e.slot, o_slot);
            n_errors++;
        end
        if (o_key_addr !== e.key) begin
            $error("key_addr: expected %h, got %h", e.key, o_key_addr);
            n_errors++;
        end
        if (o_unified_op !== e.op) begin
            $error("unified_op: expected %0d, got %0d", e.op, o_unified_op);
            n_errors++;
        end
        if (o_was_interesting !== e.intr) begin
            $error("was_interesting: expected %0d, got %0d", e.intr, o_was_interesting);
            n_errors++;
        end
        if (o_total_count !== e.total) begin
            $error("total_count: expected %0d, got %0d", e.total, o_total_count);
            n_errors++;
        end
        if (o_interesting_count !== e.icount) begin
            $error("interesting_count: expected %0d, got %0d", e.icount,
                   o_interesting_count);
            n_errors++;
        end
        if (o_op_count !== e.opcount) begin
            $error("op_count: expected %0d, got %0d", e.opcount, o_op_count);
            n_errors++;
        end
    endtask

    // Mostly back-to-back, sometimes short gaps, rarely long ones.
    function automatic int draw_gap(inout int calm);
        int p;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        p = $urandom_range(0, 99);
        if (p < 2) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (p < 50) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 100);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                mask_model = i_cfg_interesting_mask;
            end
            if (i_in_valid && !o_in_stall) begin
                expected_results.insert(expected_results.size(), count_request(cur_req));
                n_accepted++;
                in_fired = 1'b1;
            end else begin
                in_fired = 1'b0;
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result arrived with nothing expected");
                    n_errors++;
                end else begin
                    check_result(expected_results.pop_front());
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_in_valid && !in_fired) begin
            // hold the stalled request
        end else if (in_gap > 0) begin
            i_in_valid <= 1'b0;
            in_gap = in_gap - 1;
        end else if (pending_reqs.size() != 0) begin
            cur_req    <= pending_reqs.pop_front();
            i_in_valid <= 1'b1;
            in_gap = draw_gap(in_calm);
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
            stall_left = draw_gap(stall_calm);
        end
    end

    function automatic void queue_req(input t_nfs_req r);
        pending_reqs.insert(pending_reqs.size(), r);
        n_queued++;
    endfunction

    function automatic t_nfs_req mk_record(input logic call, input logic [7:0] ver,
                                           input logic [7:0] proc,
                                           input logic [ADDR_W-1:0] addr);
        t_nfs_req r;
        r         = '0;
        r.kind    = REQ_RECORD;
        r.is_call = call;
        r.ver     = ver;
        r.proc    = proc;
        r.addr    = addr;
        return r;
    endfunction

    function automatic t_nfs_req mk_read(input logic [SLOT_W-1:0] slot,
                                         input logic [OP_W-1:0] op);
        t_nfs_req r;
        r       = '0;
        r.kind  = REQ_READ;
        r.rslot = slot;
        r.rop   = op;
        return r;
    endfunction

    // Mostly well-formed calls from a pool of clients, with some noise and reads.
    function automatic t_nfs_req rand_req(input int pool_hi, input int slot_hi);
        t_nfs_req r;
        int sel;
        r.is_call = 1'($urandom);
        r.ver     = 8'($urandom);
        r.proc    = 8'($urandom);
        r.addr    = $urandom;
        r.rslot   = SLOT_W'($urandom);
        r.rop     = OP_W'($urandom);
        if ($urandom_range(0, 4) == 0) begin
            r.kind = REQ_READ;
            if ($urandom_range(0, 3) != 0) begin
                r.rslot = SLOT_W'($urandom_range(0, slot_hi));
            end
            if ($urandom_range(0, 7) != 0) begin
                r.rop = OP_W'($urandom_range(0, NUM_OPS - 1));
            end
            return r;
        end
        r.kind    = REQ_RECORD;
        r.is_call = ($urandom_range(0, 9) != 0);
        r.addr    = addr_pool[$urandom_range(0, pool_hi)];
        sel = $urandom_range(0, 19);
        if (sel != 0) begin
            r.ver = sel[0] ? NFS_V2 : NFS_V3;
        end
        if ($urandom_range(0, 11) != 0) begin
            if (r.ver == NFS_V3) begin
                r.proc = 8'($urandom_range(0, V3_PROCS - 1));
            end else begin
                r.proc = 8'($urandom_range(0, V2_PROCS - 1));
            end
        end
        return r;
    endfunction

    task automatic wait_drained();
        while (n_accepted != n_queued || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_mask(input logic [NUM_OPS-1:0] value);
        i_cfg_valid            <= 1'b1;
        i_cfg_interesting_mask <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input logic [NUM_OPS-1:0] mask, input int count,
                              input int pool_hi, input int slot_hi);
        wait_drained();
        write_mask(mask);
        for (int k = 0; k < count; k++) begin
            queue_req(rand_req(pool_hi, slot_hi));
        end
    endtask

    initial begin
        for (int s = 0; s < CLIENT_SLOTS; s++) begin
            slot_used[s] = 1'b0;
            slot_addr[s] = '0;
            call_cnt[s]  = '0;
            intr_cnt[s]  = '0;
            for (int u = 0; u < NUM_OPS; u++) begin
                op_cnt[s][u] = '0;
            end
        end
        for (int k = 0; k < POOL_SIZE; k++) begin
            addr_pool[k] = $urandom;
        end

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        write_mask({NUM_OPS{1'b1}});

        // extremes of the address, of the procedure tables and of the versions
        queue_req(mk_record(1'b1, NFS_V2, 8'd0, 32'h0000_0000));
        queue_req(mk_record(1'b1, NFS_V2, 8'd17, 32'hFFFF_FFFF));
        queue_req(mk_record(1'b1, NFS_V3, 8'd0, addr_pool[0]));
        queue_req(mk_record(1'b1, NFS_V3, 8'd4, addr_pool[0]));
        queue_req(mk_record(1'b1, NFS_V3, 8'd11, addr_pool[0]));
        queue_req(mk_record(1'b1, NFS_V3, 8'd17, addr_pool[0]));
        queue_req(mk_record(1'b1, NFS_V3, 8'd19, addr_pool[0]));
        queue_req(mk_record(1'b1, NFS_V3, 8'd20, addr_pool[0]));
        queue_req(mk_record(1'b1, NFS_V3, 8'd21, addr_pool[0]));
        queue_req(mk_record(1'b1, NFS_V2, 8'd18, addr_pool[1]));
        queue_req(mk_record(1'b1, NFS_V3, 8'd22, addr_pool[1]));
        queue_req(mk_record(1'b1, NFS_V3, 8'd255, addr_pool[1]));
        queue_req(mk_record(1'b1, 8'd0, 8'd1, addr_pool[1]));
        queue_req(mk_record(1'b1, 8'd4, 8'd1, addr_pool[1]));
        queue_req(mk_record(1'b1, 8'd255, 8'd1, addr_pool[1]));
        queue_req(mk_record(1'b0, NFS_V3, 8'd4, addr_pool[1]));
        queue_req(mk_record(1'b0, 8'd255, 8'd255, 32'hFFFF_FFFF));
        queue_req(mk_record(1'b1, NFS_V2, 8'd0, 32'h0000_0000));
        queue_req(mk_read(6'd0, 5'd0));
        queue_req(mk_read(6'd1, 5'd17));
        queue_req(mk_read(6'd2, 5'd23));
        queue_req(mk_read(6'd2, 5'd24));
        queue_req(mk_read(6'd2, 5'd31));
        queue_req(mk_read(6'd63, 5'd5));
        queue_req(mk_read(6'd63, 5'd31));

        run_random('0, 300, 29, 40);
        run_random(NUM_OPS'($urandom), 600, 29, 40);
        run_random({NUM_OPS{1'b1}}, 350, 29, 40);
        // wider client pool: the table fills and further new clients are turned away
        run_random(NUM_OPS'($urandom), 550, POOL_SIZE - 1, CLIENT_SLOTS - 1);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

/* nfs_op_per_client_counter_top.f */
+incdir+rtl
rtl/nfsc_pkg.sv
rtl/nfsc_ram.sv
rtl/nfsc_cell.sv
rtl/nfsc_tail.sv
rtl/nfs_op_per_client_counter_top.sv
dv/testbench.sv
